// ----- rtl/iee_pkg.sv -----
package iee_pkg;

   localparam int MAX_TERMS  = 256;
   localparam int MAX_QUBITS = 32;

   localparam int ADDR_W   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W    = $clog2(MAX_TERMS + 1);
   localparam int QIDX_W   = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
   localparam int QCNT_W   = $clog2(MAX_QUBITS + 1);

   localparam int OP_W     = 2;
   localparam int TERM_W   = 8;
   localparam int QUBIT_W  = 5;
   localparam int CODE_W   = 2;
   localparam int COEF_W   = 32;
   localparam int ASSIGN_W = 32;
   localparam int ENERGY_W = 48;
   localparam int ERROR_W  = 2;

   localparam int TERMS_CFG_W  = 9;
   localparam int QUBITS_CFG_W = 6;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 9;

   localparam logic [OP_W-1:0] OP_WR_COEF = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_CODE = 2'd1;
   localparam logic [OP_W-1:0] OP_EVAL    = 2'd2;

   localparam logic [CODE_W-1:0] PAULI_I = 2'd0;
   localparam logic [CODE_W-1:0] PAULI_X = 2'd1;
   localparam logic [CODE_W-1:0] PAULI_Y = 2'd2;
   localparam logic [CODE_W-1:0] PAULI_Z = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TERMS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUBITS = 1'd1;

   typedef enum logic [ERROR_W-1:0] {
      ERR_NONE   = 2'd0,
      ERR_XY     = 2'd1,
      ERR_ZCOUNT = 2'd2
   } error_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic wr_coef;
      logic wr_code;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic issue_last;
      logic pipe_busy;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- rtl/ising_energy_evaluator.sv -----
// Write words (ops 0 and 1) and unused op 3 are taken one per cycle while the block is idle and give no result.
// Evaluate: the walk reads one coefficient and one code row per cycle from the term tables (no
// term is read when none are in use); each term passes the read and decode registers before it
// is added to the sum. The next word is accepted once the evaluation result sits in the output register.
// Reset (synchronous, active high) clears both config registers and all control; term tables
// are not cleared and must be written before use.
module ising_energy_evaluator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [iee_pkg::OP_W-1:0]              req_op,
   input  logic [iee_pkg::TERM_W-1:0]            req_term_index,
   input  logic [iee_pkg::QUBIT_W-1:0]           req_qubit_index,
   input  logic [iee_pkg::CODE_W-1:0]            req_pauli_code,
   input  logic signed [iee_pkg::COEF_W-1:0]     req_coefficient,
   input  logic [iee_pkg::ASSIGN_W-1:0]          req_assignment,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [iee_pkg::ENERGY_W-1:0]   rsp_energy,
   output logic [iee_pkg::ERROR_W-1:0]           rsp_error,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [iee_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [iee_pkg::CSR_DATA_W-1:0]        csr_data
);

   iee_pkg::ctrl_cmd_type  cmd;
   iee_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   iee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   iee_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_term_index  (req_term_index),
      .req_qubit_index (req_qubit_index),
      .req_pauli_code  (req_pauli_code),
      .req_coefficient (req_coefficient),
      .req_assignment  (req_assignment),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_energy      (rsp_energy),
      .rsp_error       (rsp_error)
   );

endmodule

// ----- rtl/iee_datapath.sv -----
module iee_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  iee_pkg::ctrl_cmd_type                 cmd,
   output iee_pkg::dp_status_type                status,
   input  logic [iee_pkg::TERM_W-1:0]            req_term_index,
   input  logic [iee_pkg::QUBIT_W-1:0]           req_qubit_index,
   input  logic [iee_pkg::CODE_W-1:0]            req_pauli_code,
   input  logic signed [iee_pkg::COEF_W-1:0]     req_coefficient,
   input  logic [iee_pkg::ASSIGN_W-1:0]          req_assignment,
   input  logic                                  csr_valid,
   input  logic [iee_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [iee_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [iee_pkg::ENERGY_W-1:0]   rsp_energy,
   output logic [iee_pkg::ERROR_W-1:0]           rsp_error
);

   logic [iee_pkg::TERMS_CFG_W-1:0]  terms_ff, terms_in;
   logic [iee_pkg::QUBITS_CFG_W-1:0] qubits_ff, qubits_in;

   logic [iee_pkg::COEF_W-1:0]                        coef_mem [iee_pkg::MAX_TERMS];
   logic [iee_pkg::MAX_QUBITS-1:0][iee_pkg::CODE_W-1:0] row_mem [iee_pkg::MAX_TERMS];

   logic [iee_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [iee_pkg::CNT_W-1:0]    n_sat;
   logic [iee_pkg::QCNT_W-1:0]   q_sat;
   logic [iee_pkg::ADDR_W-1:0]   wr_addr;
   logic [iee_pkg::QIDX_W-1:0]   wr_qubit;
   logic                         term_ok, qubit_ok;

   logic [iee_pkg::ASSIGN_W-1:0]                      assign_ff;
   logic                                              rd_valid_ff;
   logic [iee_pkg::COEF_W-1:0]                        rd_coef_ff;
   logic [iee_pkg::MAX_QUBITS-1:0][iee_pkg::CODE_W-1:0] rd_row_ff;

   logic [iee_pkg::MAX_QUBITS-1:0] meas;
   logic [iee_pkg::MAX_QUBITS-1:0] z_vec;
   logic [iee_pkg::MAX_QUBITS-1:0] bad_vec;
   logic                           parity;
   iee_pkg::error_type             term_err;

   logic                           dec_valid_ff;
   logic signed [iee_pkg::COEF_W-1:0] dec_coef_ff;
   logic                           dec_neg_ff;
   iee_pkg::error_type             dec_err_ff;

   logic signed [iee_pkg::ENERGY_W-1:0] acc_ff, acc_in;
   logic signed [iee_pkg::ENERGY_W-1:0] addend;
   iee_pkg::error_type                  err_ff, err_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [iee_pkg::ENERGY_W-1:0] rsp_energy_ff;
   logic [iee_pkg::ERROR_W-1:0]         rsp_error_ff;

   // configuration
   always_comb begin
      terms_in  = terms_ff;
      qubits_in = qubits_ff;
      if (csr_valid) begin
         unique case (csr_index)
            iee_pkg::CSR_TERMS:  terms_in  = iee_pkg::TERMS_CFG_W'(csr_data);
            iee_pkg::CSR_QUBITS: qubits_in = iee_pkg::QUBITS_CFG_W'(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         terms_ff  <= '0;
         qubits_ff <= '0;
      end else begin
         terms_ff  <= terms_in;
         qubits_ff <= qubits_in;
      end
   end

   assign n_sat = (32'(terms_ff) > iee_pkg::MAX_TERMS) ?
                  iee_pkg::CNT_W'(iee_pkg::MAX_TERMS) : iee_pkg::CNT_W'(terms_ff);
   assign q_sat = (32'(qubits_ff) > iee_pkg::MAX_QUBITS) ?
                  iee_pkg::QCNT_W'(iee_pkg::MAX_QUBITS) : iee_pkg::QCNT_W'(qubits_ff);

   // table writes
   assign wr_addr  = iee_pkg::ADDR_W'(req_term_index);
   assign wr_qubit = iee_pkg::QIDX_W'(req_qubit_index);
   assign term_ok  = 32'(req_term_index) < iee_pkg::MAX_TERMS;
   assign qubit_ok = 32'(req_qubit_index) < iee_pkg::MAX_QUBITS;

   always_ff @(posedge clock) begin
      if (cmd.wr_coef && term_ok) begin
         coef_mem[wr_addr] <= req_coefficient;
      end
      if (cmd.wr_code && term_ok && qubit_ok) begin
         row_mem[wr_addr][wr_qubit] <= req_pauli_code;
      end
   end

   // term walk and read stage
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.start) begin
         cnt_in = '0;
      end else if (cmd.issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         rd_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         assign_ff <= req_assignment;
      end
      if (cmd.issue) begin
         rd_coef_ff <= coef_mem[cnt_ff[iee_pkg::ADDR_W-1:0]];
         rd_row_ff  <= row_mem[cnt_ff[iee_pkg::ADDR_W-1:0]];
      end
   end

   // term decode
   assign meas = iee_pkg::MAX_QUBITS'(assign_ff);

   always_comb begin
      for (int q = 0; q < iee_pkg::MAX_QUBITS; q++) begin
         z_vec[q]   = (iee_pkg::QCNT_W'(q) < q_sat) && (rd_row_ff[q] == iee_pkg::PAULI_Z);
         bad_vec[q] = (iee_pkg::QCNT_W'(q) < q_sat) &&
                      ((rd_row_ff[q] == iee_pkg::PAULI_X) ||
                       (rd_row_ff[q] == iee_pkg::PAULI_Y));
      end
      parity = ^(z_vec & meas);
      if (|bad_vec) begin
         term_err = iee_pkg::ERR_XY;
      end else if ($countones(z_vec) > 2) begin
         term_err = iee_pkg::ERR_ZCOUNT;
      end else begin
         term_err = iee_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         dec_coef_ff <= rd_coef_ff;
         dec_neg_ff  <= parity;
         dec_err_ff  <= term_err;
      end
   end

   // accumulate; first faulty term freezes the sum
   assign addend = dec_neg_ff ? -iee_pkg::ENERGY_W'(dec_coef_ff)
                              :  iee_pkg::ENERGY_W'(dec_coef_ff);

   always_comb begin
      acc_in = acc_ff;
      err_in = err_ff;
      if (cmd.start) begin
         acc_in = '0;
         err_in = iee_pkg::ERR_NONE;
      end else if (dec_valid_ff && (err_ff == iee_pkg::ERR_NONE)) begin
         if (dec_err_ff != iee_pkg::ERR_NONE) begin
            err_in = dec_err_ff;
         end else begin
            acc_in = acc_ff + addend;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         err_ff <= iee_pkg::ERR_NONE;
      end else begin
         acc_ff <= acc_in;
         err_ff <= err_in;
      end
   end

   // result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_energy_ff <= (err_ff == iee_pkg::ERR_NONE) ? acc_ff : '0;
         rsp_error_ff  <= err_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_energy = rsp_energy_ff;
   assign rsp_error  = rsp_error_ff;

   assign status.n_zero     = (n_sat == '0);
   assign status.issue_last = (cnt_ff == iee_pkg::CNT_W'(n_sat - 1'b1));
   assign status.pipe_busy  = rd_valid_ff || dec_valid_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   a_frozen_after_error: assert property (@(posedge clock) disable iff (reset)
      (err_ff != iee_pkg::ERR_NONE) && !cmd.start |=> $stable(acc_ff))
      else $error("sum changed after error");

   a_error_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_error_ff != iee_pkg::ERR_NONE) |-> (rsp_energy_ff == '0))
      else $error("nonzero energy with error");

   a_no_load_mid_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rd_valid_ff && !dec_valid_ff && !cmd.issue)
      else $error("result loaded while terms in flight");

endmodule

// ----- rtl/iee_ctrl.sv -----
module iee_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [iee_pkg::OP_W-1:0]      req_op,
   input  iee_pkg::dp_status_type        status,
   output iee_pkg::ctrl_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RUN   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.wr_coef = (req_op == iee_pkg::OP_WR_COEF);
               cmd.wr_code = (req_op == iee_pkg::OP_WR_CODE);
               if (req_op == iee_pkg::OP_EVAL) begin
                  cmd.start = 1'b1;
                  state_in  = status.n_zero ? S_DRAIN : S_RUN;
               end
            end
         end
         S_RUN: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_eval_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept && (req_op == iee_pkg::OP_EVAL) |=> (state_ff != S_IDLE))
      else $error("evaluate did not start");

   a_done_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> !status.pipe_busy)
      else $error("done with pipeline busy");

endmodule
